>>> design/mmu_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit package
// Shared widths, command and register codes, and the pipeline tag type.
// ----------------------------------------------------------------------------
`default_nettype none

package mmu_pkg;

   // Field widths fixed by the item format.
   localparam int CMD_BITS     = 2;
   localparam int COORD_BITS   = 3;
   localparam int DIM_BITS     = 4;
   localparam int RESULT_BITS  = 35;
   localparam int CSR_IDX_BITS = 2;

   // Reset value of every dimension register.
   localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_RUN    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROWS_M  = 2'd0,
      CSR_INNER_K = 2'd1,
      CSR_COLS_N  = 2'd2
   } csr_index_type;

   // Travels with each multiply through the pipeline.
   typedef struct packed {
      logic                  valid;
      logic                  first;     // first term of a dot product
      logic                  last;      // last term of a dot product
      logic                  final_one; // last term of the last element of a run
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } tag_type;

endpackage

`default_nettype wire

>>> design/mmu_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmu_req_if #(
   parameter int ELEMENT_BITS = 16
);
   import mmu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_BITS-1:0]     command;
   logic [COORD_BITS-1:0]   row_index;
   logic [COORD_BITS-1:0]   col_index;
   logic [ELEMENT_BITS-1:0] element_value;

   modport source (output valid, command, row_index, col_index, element_value,
                   input ready);
   modport sink   (input valid, command, row_index, col_index, element_value,
                   output ready);
endinterface

interface mmu_rsp_if;
   import mmu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [RESULT_BITS-1:0] product_value;
   logic [COORD_BITS-1:0]  out_row;
   logic [COORD_BITS-1:0]  out_col;
   logic                   last_of_run;

   modport source (output valid, product_value, out_row, out_col, last_of_run,
                   input ready);
   modport sink   (input valid, product_value, out_row, out_col, last_of_run,
                   output ready);
endinterface

interface mmu_csr_if;
   import mmu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] reg_index;
   logic [DIM_BITS-1:0]     write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

>>> design/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit
// Computes C = A x B from two loaded stores, one MAC a cycle unless stalled.
// ----------------------------------------------------------------------------
// Load words are accepted back to back while no run is being walked.
// A run word keeps the block busy while the sequencer walks all M*N*K terms,
// one multiply-accumulate per cycle through the shared MAC unless stalled;
// one result word per K terms leaves through the output register.
// Reset restores the dimension registers to 8 and empties the pipeline; the
// element stores are not cleared.
`default_nettype none

module matrix_multiply_unit #(
   parameter int MAX_DIM      = 8,
   parameter int ELEMENT_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   mmu_req_if.sink   req_bus,
   mmu_rsp_if.source rsp_bus,
   mmu_csr_if.sink   csr_bus
);
   import mmu_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(DEPTH);

   // Dimension registers, written through the register channel.
   logic [DIM_BITS-1:0] rows_m_ff, rows_m_in;
   logic [DIM_BITS-1:0] inner_k_ff, inner_k_in;
   logic [DIM_BITS-1:0] cols_n_ff, cols_n_in;

   logic              req_fire;
   logic              in_range;
   logic              wr_a;
   logic              wr_b;
   logic              start;
   logic [ADDR_W-1:0] wr_addr;
   logic              busy;
   logic              rd_en;
   logic              advance;
   logic [ADDR_W-1:0] a_addr;
   logic [ADDR_W-1:0] b_addr;
   logic [ELEMENT_BITS-1:0] a_data;
   logic [ELEMENT_BITS-1:0] b_data;
   tag_type           tag;

   // The register channel never stalls.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      rows_m_in  = rows_m_ff;
      inner_k_in = inner_k_ff;
      cols_n_in  = cols_n_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            CSR_ROWS_M:  rows_m_in  = csr_bus.write_data;
            CSR_INNER_K: inner_k_in = csr_bus.write_data;
            CSR_COLS_N:  cols_n_in  = csr_bus.write_data;
            default:     ;  // Writes to unused indexes are dropped.
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= DIM_RESET;
         inner_k_ff <= DIM_RESET;
         cols_n_ff  <= DIM_RESET;
      end else begin
         rows_m_ff  <= rows_m_in;
         inner_k_ff <= inner_k_in;
         cols_n_ff  <= cols_n_in;
      end
   end

   // Requests are taken whenever the sequencer is not walking a run. Loads
   // may land while the last products of a run are still draining, since
   // every read of that run has already been issued.
   assign req_bus.ready = !busy;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // A load outside the store is dropped; command 3 does nothing.
   assign in_range = ({1'b0, req_bus.row_index} < (COORD_BITS + 1)'(MAX_DIM)) &&
                     ({1'b0, req_bus.col_index} < (COORD_BITS + 1)'(MAX_DIM));
   assign wr_a     = req_fire && in_range && (req_bus.command == CMD_LOAD_A);
   assign wr_b     = req_fire && in_range && (req_bus.command == CMD_LOAD_B);
   assign start    = req_fire && (req_bus.command == CMD_RUN);
   assign wr_addr  = ADDR_W'(req_bus.row_index[IDX_W-1:0]) * ADDR_W'(MAX_DIM) +
                     ADDR_W'(req_bus.col_index[IDX_W-1:0]);

   // Element stores for A and B, both row-major at row * MAX_DIM + column.
   mmu_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_bus.element_value),
      .rd_en   (rd_en),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mmu_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_bus.element_value),
      .rd_en   (rd_en),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   // The sequencer steps the inner index fastest, then the column, then
   // the row, so results leave in row-major order.
   mmu_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .rows_m  (rows_m_ff),
      .inner_k (inner_k_ff),
      .cols_n  (cols_n_ff),
      .advance (advance),
      .busy    (busy),
      .rd_en   (rd_en),
      .a_addr  (a_addr),
      .b_addr  (b_addr),
      .tag     (tag)
   );

   // Multiplier and accumulator; a full output register stalls everything
   // behind it, including the store reads.
   mmu_mac #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .tag     (tag),
      .a_data  (a_data),
      .b_data  (b_data),
      .advance (advance),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

>>> design/mmu_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/mmu_seq.sv
// ----------------------------------------------------------------------------
// Matrix multiply sequencer
// Walks a run's row, column and inner index; one read pair a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mmu_seq #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [mmu_pkg::DIM_BITS-1:0]         rows_m,
   input  wire logic [mmu_pkg::DIM_BITS-1:0]         inner_k,
   input  wire logic [mmu_pkg::DIM_BITS-1:0]         cols_n,
   input  wire logic                                 advance,
   output      logic                                 busy,
   output      logic                                 rd_en,
   output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
   output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
   output      mmu_pkg::tag_type                     tag
);
   import mmu_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [IDX_W-1:0] m_last_ff, m_last_in;
   logic [IDX_W-1:0] k_last_ff, k_last_in;
   logic [IDX_W-1:0] n_last_ff, n_last_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic [IDX_W-1:0] t_ff, t_in;
   tag_type          tag_ff, tag_in;
   logic             issue;

   // Zero acts as one and anything above the store size saturates.
   function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_BITS-1:0] v);
      logic [IDX_W-1:0] res;
      priority if (v == '0) begin
         res = '0;
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         res = IDX_W'(MAX_DIM - 1);
      end else begin
         res = IDX_W'(v - DIM_BITS'(1));
      end
      return res;
   endfunction

   assign issue = (state_ff == SEQ_RUN) && advance;

   always_comb begin
      state_in  = state_ff;
      m_last_in = m_last_ff;
      k_last_in = k_last_ff;
      n_last_in = n_last_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      t_in      = t_ff;
      tag_in    = tag_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in  = SEQ_RUN;
               m_last_in = dim_last(rows_m);
               k_last_in = dim_last(inner_k);
               n_last_in = dim_last(cols_n);
               r_in      = '0;
               c_in      = '0;
               t_in      = '0;
            end
         end
         SEQ_RUN: begin
            if (issue) begin
               if (t_ff == k_last_ff) begin
                  t_in = '0;
                  if (c_ff == n_last_ff) begin
                     c_in = '0;
                     if (r_ff == m_last_ff) begin
                        state_in = SEQ_IDLE;
                     end else begin
                        r_in = r_ff + IDX_W'(1);
                     end
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                  end
               end else begin
                  t_in = t_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      // The tag lines up with the registered RAM data and holds on a stall.
      if (advance) begin
         tag_in.valid     = issue;
         tag_in.first     = (t_ff == '0);
         tag_in.last      = (t_ff == k_last_ff);
         tag_in.final_one = (t_ff == k_last_ff) && (c_ff == n_last_ff) &&
                            (r_ff == m_last_ff);
         tag_in.row       = COORD_BITS'(r_ff);
         tag_in.col       = COORD_BITS'(c_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         tag_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff.valid <= tag_in.valid;
      end
      m_last_ff        <= m_last_in;
      k_last_ff        <= k_last_in;
      n_last_ff        <= n_last_in;
      r_ff             <= r_in;
      c_ff             <= c_in;
      t_ff             <= t_in;
      tag_ff.first     <= tag_in.first;
      tag_ff.last      <= tag_in.last;
      tag_ff.final_one <= tag_in.final_one;
      tag_ff.row       <= tag_in.row;
      tag_ff.col       <= tag_in.col;
   end

   assign busy   = (state_ff == SEQ_RUN);
   assign rd_en  = issue;
   assign a_addr = ADDR_W'(r_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(t_ff);
   assign b_addr = ADDR_W'(t_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(c_ff);
   assign tag    = tag_ff;

endmodule

`default_nettype wire

>>> design/mmu_mac.sv
// ----------------------------------------------------------------------------
// Matrix multiply MAC unit
// Registered multiplier, accumulator and output register for result words.
// ----------------------------------------------------------------------------
`default_nettype none

module mmu_mac #(
   parameter int ELEMENT_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mmu_pkg::tag_type        tag,
   input  wire logic [ELEMENT_BITS-1:0] a_data,
   input  wire logic [ELEMENT_BITS-1:0] b_data,
   output      logic                    advance,
   mmu_rsp_if.source                    rsp_bus
);
   import mmu_pkg::*;

   localparam int PROD_W = 2 * ELEMENT_BITS;

   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   tag_type                       ptag_ff, ptag_in;
   logic signed [RESULT_BITS-1:0] prod_ext;
   logic signed [RESULT_BITS-1:0] sum;
   logic signed [RESULT_BITS-1:0] acc_ff, acc_in;
   logic                          out_valid_ff, out_valid_in;
   logic [RESULT_BITS-1:0]        out_value_ff, out_value_in;
   logic [COORD_BITS-1:0]         out_row_ff, out_row_in;
   logic [COORD_BITS-1:0]         out_col_ff, out_col_in;
   logic                          out_last_ff, out_last_in;
   logic                          finish;

   // The whole pipeline holds while a result word waits to be taken.
   assign advance = !out_valid_ff || rsp_bus.ready;

   // Sign-extend or wrap the product to the result width.
   assign prod_ext = RESULT_BITS'(prod_ff);
   assign sum      = ptag_ff.first ? prod_ext : acc_ff + prod_ext;
   assign finish   = advance && ptag_ff.valid && ptag_ff.last;

   always_comb begin
      prod_in      = prod_ff;
      ptag_in      = ptag_ff;
      acc_in       = acc_ff;
      out_value_in = out_value_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (advance) begin
         prod_in = $signed(a_data) * $signed(b_data);
         ptag_in = tag;
         if (ptag_ff.valid) begin
            acc_in = sum;
         end
      end
      if (finish) begin
         out_valid_in = 1'b1;
         out_value_in = sum;
         out_row_in   = ptag_ff.row;
         out_col_in   = ptag_ff.col;
         out_last_in  = ptag_ff.final_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptag_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         ptag_ff.valid <= ptag_in.valid;
         out_valid_ff  <= out_valid_in;
      end
      prod_ff           <= prod_in;
      ptag_ff.first     <= ptag_in.first;
      ptag_ff.last      <= ptag_in.last;
      ptag_ff.final_one <= ptag_in.final_one;
      ptag_ff.row       <= ptag_in.row;
      ptag_ff.col       <= ptag_in.col;
      acc_ff            <= acc_in;
      out_value_ff      <= out_value_in;
      out_row_ff        <= out_row_in;
      out_col_ff        <= out_col_in;
      out_last_ff       <= out_last_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.product_value = out_value_ff;
   assign rsp_bus.out_row       = out_row_ff;
   assign rsp_bus.out_col       = out_col_ff;
   assign rsp_bus.last_of_run   = out_last_ff;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply unit testbench
// Loads elements of A and B, issues multiply runs under several dimension
// settings, and checks every result word against an in-bench predictor.
// ----------------------------------------------------------------------------

module tb;
   import mmu_pkg::*;

   localparam int MAX_DIM       = 8;
   localparam int ELEM_BITS     = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   // Quiet cycles after the last result, so that any trailing activity is covered.
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_MAX    = 10;

   // The fourth command code has no meaning and must be dropped by the block.
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // One word on the request channel.
   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic [ELEM_BITS-1:0]  value;
   } request_word_type;

   // One element of C as the block should report it.
   typedef struct packed {
      logic [RESULT_BITS-1:0] sum;
      logic [COORD_BITS-1:0]  row;
      logic [COORD_BITS-1:0]  col;
      logic                   last;
   } product_word_type;

   logic clock;
   logic reset;

   mmu_req_if #(.ELEMENT_BITS(ELEM_BITS)) req_bus ();
   mmu_rsp_if                             rsp_bus ();
   mmu_csr_if                             csr_bus ();

   matrix_multiply_unit #(
      .MAX_DIM      (MAX_DIM),
      .ELEMENT_BITS (ELEM_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Words waiting to be offered, and the word currently on the channel.
   request_word_type pending_words [$];
   request_word_type offered_word;
   int               words_queued;
   int               words_accepted;

   // Predictor state: element stores and dimension registers as the block
   // should hold them after every accepted word and register write.
   logic signed [ELEM_BITS-1:0] a_elems [MAX_DIM][MAX_DIM];
   logic signed [ELEM_BITS-1:0] b_elems [MAX_DIM][MAX_DIM];
   logic [DIM_BITS-1:0]         dim_regs [3];
   product_word_type            expected_products [$];

   // Stimulus bookkeeping: which entries have been loaded so far, so that a
   // run never reads an entry that was never written, and the dimensions in
   // force for the phase being generated.
   bit a_loaded [MAX_DIM][MAX_DIM];
   bit b_loaded [MAX_DIM][MAX_DIM];
   int gen_m;
   int gen_k;
   int gen_n;

   int mismatches;
   int cycle_count;
   int hold_request;
   bit quiet;

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A register value of zero acts as one, anything above the store size
   // saturates to the store size.
   function automatic int effective_dim(input logic [DIM_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Element values lean on the extremes so that the widest sums show up.
   function automatic logic [ELEM_BITS-1:0] random_element();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return ELEM_BITS'($urandom);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Predictor: applies one accepted request word. Loads update the stores,
   // a run queues every element of C in row-major order.
   // -------------------------------------------------------------------------
   task automatic predict_word(input request_word_type w);
      int               m;
      int               k;
      int               n;
      int               r;
      int               c;
      int               t;
      longint           acc;
      product_word_type p;
      case (w.command)
         CMD_LOAD_A: a_elems[w.row][w.col] = w.value;
         CMD_LOAD_B: b_elems[w.row][w.col] = w.value;
         CMD_RUN: begin
            m = effective_dim(dim_regs[CSR_ROWS_M]);
            k = effective_dim(dim_regs[CSR_INNER_K]);
            n = effective_dim(dim_regs[CSR_COLS_N]);
            for (r = 0; r < m; r++) begin
               for (c = 0; c < n; c++) begin
                  acc = 0;
                  for (t = 0; t < k; t++) begin
                     acc += longint'(a_elems[r][t]) * longint'(b_elems[t][c]);
                  end
                  p.sum  = acc[RESULT_BITS-1:0];
                  p.row  = COORD_BITS'(r);
                  p.col  = COORD_BITS'(c);
                  p.last = (r == m - 1) && (c == n - 1);
                  expected_products.push_back(p);
               end
            end
         end
         default: ;
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Request driver. A word stays on the channel until it is taken; between
   // words the sender may go quiet for a random burst.
   // -------------------------------------------------------------------------
   int req_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_word(offered_word);
            words_accepted++;
         end
         // Only move on when nothing is left waiting on the channel.
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0 && !quiet &&
                         $urandom_range(0, 7) == 0) begin
               // This cycle opens a gap whose length is drawn at random.
               req_gap = $urandom_range(0, 12);
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               offered_word = pending_words.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.command       <= offered_word.command;
               req_bus.row_index     <= offered_word.row;
               req_bus.col_index     <= offered_word.col;
               req_bus.element_value <= offered_word.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver. It stalls in random bursts, and once during the run
   // holds off for a long stretch so that the block backs up into its input.
   // -------------------------------------------------------------------------
   int hold_left;
   int stall_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left  = 0;
         stall_left = 0;
      end else begin
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: every accepted result word is matched against the
   // oldest expected element.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      product_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_products.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected result word sum %0d row %0d col %0d last %0b",
                        $realtime, $signed(rsp_bus.product_value), rsp_bus.out_row,
                        rsp_bus.out_col, rsp_bus.last_of_run);
         end else begin
            want = expected_products.pop_front();
            if (rsp_bus.product_value !== want.sum || rsp_bus.out_row !== want.row ||
                rsp_bus.out_col !== want.col || rsp_bus.last_of_run !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: result mismatch, expected sum %0d row %0d col %0d ",
                           $realtime, $signed(want.sum), want.row, want.col,
                           "last %0b, got sum %0d row %0d col %0d last %0b",
                           want.last, $signed(rsp_bus.product_value), rsp_bus.out_row,
                           rsp_bus.out_col, rsp_bus.last_of_run);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: a hung handshake or a missing result ends the run here.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic push_word(input logic [CMD_BITS-1:0] cmd, input int row, input int col,
                            input logic [ELEM_BITS-1:0] value);
      request_word_type w;
      w.command = cmd;
      w.row     = COORD_BITS'(row);
      w.col     = COORD_BITS'(col);
      w.value   = value;
      if (cmd == CMD_LOAD_A) a_loaded[w.row][w.col] = 1'b1;
      if (cmd == CMD_LOAD_B) b_loaded[w.row][w.col] = 1'b1;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Loads whatever the current dimensions would read but was never written,
   // then issues the run itself with random content in the unused fields.
   task automatic push_run();
      int r;
      int c;
      int t;
      for (r = 0; r < gen_m; r++)
         for (t = 0; t < gen_k; t++)
            if (!a_loaded[r][t]) push_word(CMD_LOAD_A, r, t, random_element());
      for (t = 0; t < gen_k; t++)
         for (c = 0; c < gen_n; c++)
            if (!b_loaded[t][c]) push_word(CMD_LOAD_B, t, c, random_element());
      push_word(CMD_RUN, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_BITS'($urandom));
   endtask

   // Writes one register; the caller is at a rising edge. The valid line is
   // left high so that back-to-back writes need no second assignment.
   task automatic write_reg(input csr_index_type idx, input logic [DIM_BITS-1:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      dim_regs[idx] = data;
   endtask

   // Only called while the block is idle.
   task automatic set_dims(input logic [DIM_BITS-1:0] m, input logic [DIM_BITS-1:0] k,
                           input logic [DIM_BITS-1:0] n);
      write_reg(CSR_ROWS_M, m);
      write_reg(CSR_INNER_K, k);
      write_reg(CSR_COLS_N, n);
      csr_bus.valid <= 1'b0;
      gen_m = effective_dim(m);
      gen_k = effective_dim(k);
      gen_n = effective_dim(n);
   endtask

   // Waits until every queued word is taken and every expected result has
   // come back, then lets the block settle.
   task automatic wait_drained();
      do @(posedge clock);
      while (words_accepted != words_queued || expected_products.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly loads that land inside the active matrices, some anywhere in the
   // store, a share of runs and a little noise from the unused command.
   // Noise words do not count toward the phase length.
   task automatic random_phase(input int count);
      int                  done;
      int                  pick;
      int                  r;
      int                  c;
      logic [CMD_BITS-1:0] cmd;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            push_run();
            done++;
         end else if (pick < 16) begin
            push_word(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                      ELEM_BITS'($urandom));
         end else begin
            if (pick < 58) begin
               cmd = CMD_LOAD_A;
               r   = $urandom_range(0, gen_m - 1);
               c   = $urandom_range(0, gen_k - 1);
            end else begin
               cmd = CMD_LOAD_B;
               r   = $urandom_range(0, gen_k - 1);
               c   = $urandom_range(0, gen_n - 1);
            end
            if ($urandom_range(0, 4) == 0) begin
               r = $urandom_range(0, 7);
               c = $urandom_range(0, 7);
            end
            push_word(cmd, r, c, random_element());
            done++;
         end
      end
      // Close each phase with a run so the last loads are seen in a result.
      push_run();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int t;

      // Every input of the block is known from time zero.
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_LOAD_A;
      req_bus.row_index     = '0;
      req_bus.col_index     = '0;
      req_bus.element_value = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.reg_index     = CSR_ROWS_M;
      csr_bus.write_data    = '0;
      words_queued          = 0;
      words_accepted        = 0;
      mismatches            = 0;
      hold_request          = 0;
      quiet                 = 1'b0;
      for (int i = 0; i < 3; i++) dim_regs[i] = DIM_RESET;
      gen_m = MAX_DIM;
      gen_k = MAX_DIM;
      gen_n = MAX_DIM;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Zero in every register: all three act as one, so C is a single
      // element. Exercise the extreme products and the ignored command.
      set_dims(4'd0, 4'd0, 4'd0);
      push_word(CMD_LOAD_A, 0, 0, 16'h8000);
      push_word(CMD_LOAD_B, 0, 0, 16'h8000);
      push_run();
      push_word(CMD_LOAD_A, 0, 0, 16'h7FFF);
      push_run();
      push_word(CMD_UNUSED, 7, 7, 16'hFFFF);
      push_word(CMD_LOAD_A, 7, 7, 16'h5555);
      push_word(CMD_LOAD_B, 7, 7, 16'hAAAA);
      push_word(CMD_LOAD_B, 0, 0, 16'h0000);
      push_run();
      wait_drained();

      // A single dot product of full length with every term at the most
      // negative value gives the largest sum that a run can produce.
      set_dims(4'd1, 4'd8, 4'd1);
      for (t = 0; t < MAX_DIM; t++) begin
         push_word(CMD_LOAD_A, 0, t, 16'h8000);
         push_word(CMD_LOAD_B, t, 0, 16'h8000);
      end
      push_run();
      wait_drained();

      set_dims(4'd2, 4'd3, 4'd4);
      random_phase(6);
      wait_drained();

      // Registers above the store size saturate. The receiver holds off for
      // a long stretch while a 64-element run is under way, so the block
      // fills up and stops taking the loads that follow.
      set_dims(4'd15, 4'd2, 4'd9);
      hold_request = HOLD_CYCLES;
      push_run();
      random_phase(6);
      wait_drained();

      set_dims(4'd3, 4'd15, 4'd1);
      random_phase(6);
      wait_drained();

      set_dims(4'd1, 4'd1, 4'd8);
      random_phase(5);
      wait_drained();

      // Last part of the run with both sides always ready.
      quiet = 1'b1;
      set_dims(4'd5, 4'd4, 4'd6);
      random_phase(6);
      wait_drained();

      if (mismatches == 0 && expected_products.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> matrix_multiply_unit.f
design/mmu_pkg.sv
design/mmu_if.sv
design/mmu_ram.sv
design/mmu_seq.sv
design/mmu_mac.sv
design/matrix_multiply_unit.sv
sim/tb.sv
